// ===== rtl/fdes_pkg.sv =====
`default_nettype none

package fdes_pkg;

  localparam int unsigned NAME_W     = 64;
  localparam int unsigned EXT_W      = 24;
  localparam int unsigned CLUSTER_W  = 32;
  localparam int unsigned HALF_W     = 16;
  localparam int unsigned SIZE_W     = 32;
  localparam int unsigned COUNT_W    = 16;
  localparam int unsigned ATTR_W     = 8;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 64;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] BYTE_END      = 8'h00;
  localparam logic [7:0] BYTE_DELETED  = 8'hE5;
  localparam logic [7:0] BYTE_DOT      = 8'h2E;
  localparam logic [7:0] BYTE_SPACE    = 8'h20;
  localparam logic [7:0] ATTR_LFN      = 8'h0F;
  localparam logic [7:0] ATTR_VOLUME   = 8'h08;
  localparam logic [7:0] ATTR_DIR      = 8'h10;

  localparam logic [NAME_W-1:0]  QUERY_BASE_RESET = {8{BYTE_SPACE}};
  localparam logic [EXT_W-1:0]   QUERY_EXT_RESET  = {3{BYTE_SPACE}};
  localparam logic [COUNT_W-1:0] LIST_LIMIT_RESET = 16'd16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCAN_MODE  = 2'd0,
    CFG_QUERY_BASE = 2'd1,
    CFG_QUERY_EXT  = 2'd2,
    CFG_LIST_LIMIT = 2'd3
  } cfg_idx_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_SKIPPED = 3'd0,
    ST_FOUND   = 3'd1,
    ST_LISTED  = 3'd2,
    ST_END     = 3'd3,
    ST_FULL    = 3'd4,
    ST_IGNORED = 3'd5
  } status_t;

  typedef enum logic {
    MODE_FIND = 1'b0,
    MODE_LIST = 1'b1
  } mode_t;

  typedef struct packed {
    mode_t              scan_mode;
    logic [NAME_W-1:0]  query_base;
    logic [EXT_W-1:0]   query_ext;
    logic [COUNT_W-1:0] list_limit;
  } cfg_t;

  // classified entry handed from front to back
  typedef struct packed {
    logic                 first_entry;
    logic                 is_end;
    logic                 is_skip;
    logic                 name_match;
    logic                 list_skip;
    logic                 is_dir;
    logic [CLUSTER_W-1:0] cluster;
    logic [SIZE_W-1:0]    size;
    logic [NAME_W-1:0]    name;
    logic [EXT_W-1:0]     ext;
  } entry_word_t;

endpackage

`default_nettype wire

// ===== rtl/fdes_if.sv =====
`default_nettype none

interface fdes_in_if
  import fdes_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              first_entry;
  logic [NAME_W-1:0] entry_name;
  logic [EXT_W-1:0]  entry_ext;
  logic [ATTR_W-1:0] entry_attributes;
  logic [HALF_W-1:0] cluster_high_half;
  logic [HALF_W-1:0] cluster_low_half;
  logic [SIZE_W-1:0] entry_file_size;

  modport source (
    output valid, first_entry, entry_name, entry_ext, entry_attributes,
           cluster_high_half, cluster_low_half, entry_file_size,
    input  ready
  );
  modport sink (
    input  valid, first_entry, entry_name, entry_ext, entry_attributes,
           cluster_high_half, cluster_low_half, entry_file_size,
    output ready
  );
endinterface

interface fdes_out_if
  import fdes_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [STATUS_W-1:0]  status;
  logic [CLUSTER_W-1:0] first_cluster;
  logic                 is_directory;
  logic [SIZE_W-1:0]    size_out;
  logic [NAME_W-1:0]    name_out;
  logic [EXT_W-1:0]     ext_out;
  logic [COUNT_W-1:0]   listed_so_far;

  modport source (
    output valid, status, first_cluster, is_directory, size_out, name_out,
           ext_out, listed_so_far,
    input  ready
  );
  modport sink (
    input  valid, status, first_cluster, is_directory, size_out, name_out,
           ext_out, listed_so_far,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/fdes_front.sv =====
`default_nettype none

module fdes_front
  import fdes_pkg::*;
(
  fdes_in_if.sink     entry_in,
  input  cfg_t        cfg,
  output logic        push_valid,
  input  logic        push_ready,
  output entry_word_t push_word
);

  // every byte at and after the first space becomes a space
  function automatic logic [NAME_W-1:0] cut_name(input logic [NAME_W-1:0] w);
    logic [NAME_W-1:0] res;
    logic              seen;
    res  = w;
    seen = 1'b0;
    for (int i = 0; i < NAME_W / 8; i++) begin
      if (w[8*i +: 8] == BYTE_SPACE) seen = 1'b1;
      if (seen) res[8*i +: 8] = BYTE_SPACE;
    end
    return res;
  endfunction

  function automatic logic [EXT_W-1:0] cut_ext(input logic [EXT_W-1:0] w);
    logic [EXT_W-1:0] res;
    logic             seen;
    res  = w;
    seen = 1'b0;
    for (int i = 0; i < EXT_W / 8; i++) begin
      if (w[8*i +: 8] == BYTE_SPACE) seen = 1'b1;
      if (seen) res[8*i +: 8] = BYTE_SPACE;
    end
    return res;
  endfunction

  logic [7:0] first_byte;
  logic [7:0] attr;

  assign first_byte = entry_in.entry_name[7:0];
  assign attr       = entry_in.entry_attributes;

  assign push_valid     = entry_in.valid;
  assign entry_in.ready = push_ready;

  always_comb begin
    push_word.first_entry = entry_in.first_entry;
    push_word.is_end      = (first_byte == BYTE_END);
    push_word.is_skip     = (first_byte == BYTE_DELETED) || (attr == ATTR_LFN);
    push_word.name_match  = (cut_name(entry_in.entry_name) == cut_name(cfg.query_base)) &&
                            (cut_ext(entry_in.entry_ext) == cut_ext(cfg.query_ext));
    push_word.list_skip   = ((attr & ATTR_VOLUME) != 8'h00) || (first_byte == BYTE_DOT);
    push_word.is_dir      = ((attr & ATTR_DIR) != 8'h00);
    push_word.cluster     = {entry_in.cluster_high_half, entry_in.cluster_low_half};
    push_word.size        = entry_in.entry_file_size;
    push_word.name        = entry_in.entry_name;
    push_word.ext         = entry_in.entry_ext;
  end

endmodule

`default_nettype wire

// ===== rtl/fdes_queue.sv =====
`default_nettype none

module fdes_queue
  import fdes_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push_valid,
  output logic        push_ready,
  input  entry_word_t push_word,
  output logic        pop_valid,
  input  logic        pop_ready,
  output entry_word_t pop_word
);

  entry_word_t            slots [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_CNT_W-1:0] count;
  logic                   push;
  logic                   pop;

  assign push_ready = (count != QUEUE_CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_word   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_word;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/fdes_back.sv =====
`default_nettype none

module fdes_back
  import fdes_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        pop_valid,
  output logic        pop_ready,
  input  entry_word_t pop_word,
  fdes_out_if.source  result_out
);

  logic               scan_done;
  logic [COUNT_W-1:0] listed_count;
  logic               scan_done_next;
  logic [COUNT_W-1:0] listed_count_next;
  logic               done_base;
  logic [COUNT_W-1:0] count_base;
  logic [COUNT_W-1:0] count_inc;

  logic                 out_valid;
  status_t              status_next;
  logic [CLUSTER_W-1:0] cluster_next;
  logic                 dir_next;
  logic [SIZE_W-1:0]    size_next;
  logic [NAME_W-1:0]    name_next;
  logic [EXT_W-1:0]     ext_next;
  logic                 pop;

  assign pop_ready = !out_valid || result_out.ready;
  assign pop       = pop_valid && pop_ready;

  assign done_base  = pop_word.first_entry ? 1'b0 : scan_done;
  assign count_base = pop_word.first_entry ? '0 : listed_count;
  assign count_inc  = count_base + 1'b1;

  always_comb begin
    status_next       = ST_SKIPPED;
    cluster_next      = '0;
    dir_next          = 1'b0;
    size_next         = '0;
    name_next         = '0;
    ext_next          = '0;
    scan_done_next    = done_base;
    listed_count_next = count_base;
    if (done_base) begin
      status_next = ST_IGNORED;
    end else if (cfg.scan_mode == MODE_LIST && count_base >= cfg.list_limit) begin
      status_next    = ST_FULL;
      scan_done_next = 1'b1;
    end else if (pop_word.is_end) begin
      status_next    = ST_END;
      scan_done_next = 1'b1;
    end else if (pop_word.is_skip) begin
      status_next = ST_SKIPPED;
    end else if (cfg.scan_mode == MODE_FIND) begin
      if (pop_word.name_match) begin
        status_next    = ST_FOUND;
        cluster_next   = pop_word.cluster;
        scan_done_next = 1'b1;
      end
    end else if (pop_word.list_skip) begin
      status_next = ST_SKIPPED;
    end else begin
      status_next       = ST_LISTED;
      cluster_next      = pop_word.cluster;
      dir_next          = pop_word.is_dir;
      size_next         = pop_word.size;
      name_next         = pop_word.name;
      ext_next          = pop_word.ext;
      listed_count_next = count_inc;
      if (count_inc >= cfg.list_limit) scan_done_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_done    <= 1'b0;
      listed_count <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (pop) begin
        scan_done    <= scan_done_next;
        listed_count <= listed_count_next;
        out_valid    <= 1'b1;
      end else if (result_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      result_out.status        <= status_next;
      result_out.first_cluster <= cluster_next;
      result_out.is_directory  <= dir_next;
      result_out.size_out      <= size_next;
      result_out.name_out      <= name_next;
      result_out.ext_out       <= ext_next;
      result_out.listed_so_far <= listed_count_next;
    end
  end

  assign result_out.valid = out_valid;

  // cluster only carried on a hit or a listed word
  a_cluster_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_out.status != ST_FOUND && result_out.status != ST_LISTED
    |-> result_out.first_cluster == '0)
    else $error("first_cluster set on a word that is neither found nor listed");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_out.status == ST_FULL
    |-> result_out.listed_so_far >= cfg.list_limit)
    else $error("list full reported below the limit");

  a_listed_name: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_out.status == ST_LISTED
    |-> result_out.name_out[7:0] != BYTE_END && result_out.name_out[7:0] != BYTE_DELETED
        && result_out.name_out[7:0] != BYTE_DOT && result_out.listed_so_far != '0)
    else $error("listed word carries an entry that should have been dropped");

endmodule

`default_nettype wire

// ===== rtl/fat_directory_entry_scanner.sv =====
// An accepted entry is written into the queue and is popped from there into the registered
// result word; a stall on the output holds it in the queue.
// Throughput: one entry per cycle while the output is not stalled.
// A two-word queue sits between front and back, so input is still taken while a
// result waits on the output register, until the queue is full.
// Reset (synchronous, rst high) clears scan state and queue and restores register defaults.
`default_nettype none

module fat_directory_entry_scanner
  import fdes_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  fdes_in_if.sink               entry_in,
  fdes_out_if.source            result_out,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t        cfg;
  logic        push_valid;
  logic        push_ready;
  entry_word_t push_word;
  logic        pop_valid;
  logic        pop_ready;
  entry_word_t pop_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.scan_mode  <= MODE_FIND;
      cfg.query_base <= QUERY_BASE_RESET;
      cfg.query_ext  <= QUERY_EXT_RESET;
      cfg.list_limit <= LIST_LIMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_SCAN_MODE:  cfg.scan_mode  <= mode_t'(cfg_data[0]);
        CFG_QUERY_BASE: cfg.query_base <= cfg_data[NAME_W-1:0];
        CFG_QUERY_EXT:  cfg.query_ext  <= cfg_data[EXT_W-1:0];
        CFG_LIST_LIMIT: cfg.list_limit <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  fdes_front u_front (
    .entry_in   (entry_in),
    .cfg        (cfg),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_word  (push_word)
  );

  fdes_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_word  (push_word),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_word   (pop_word)
  );

  fdes_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_word   (pop_word),
    .result_out (result_out)
  );

endmodule

`default_nettype wire

// ===== verif/fat_directory_entry_scanner_tb.sv =====
`default_nettype none

module fat_directory_entry_scanner_tb;
  import fdes_pkg::*;

  localparam int RANDOM_ITEMS = 1450;

  typedef struct packed {
    logic                 first_entry;
    logic [NAME_W-1:0]    name;
    logic [EXT_W-1:0]     ext;
    logic [ATTR_W-1:0]    attr;
    logic [HALF_W-1:0]    cluster_hi;
    logic [HALF_W-1:0]    cluster_lo;
    logic [SIZE_W-1:0]    size;
  } dir_entry_t;

  typedef struct packed {
    status_t              status;
    logic [CLUSTER_W-1:0] cluster;
    logic                 is_dir;
    logic [SIZE_W-1:0]    size;
    logic [NAME_W-1:0]    name;
    logic [EXT_W-1:0]     ext;
    logic [COUNT_W-1:0]   listed;
  } scan_result_t;

  typedef enum logic {ROW_ENTRY, ROW_REG} row_kind_t;

  typedef struct {
    row_kind_t         kind;
    cfg_idx_t          reg_idx;
    logic [63:0]       reg_value;
    dir_entry_t        ent;
    bit                typed;
    status_t           st;
    logic [COUNT_W-1:0] cnt;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  fdes_in_if  entry_bus ();
  fdes_out_if result_bus ();

  fat_directory_entry_scanner u_dut (
    .clk        (clk),
    .rst        (rst),
    .entry_in   (entry_bus),
    .result_out (result_bus),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow of the scanner's registers and scan state
  mode_t              cfg_mode       = MODE_FIND;
  logic [NAME_W-1:0]  cfg_query_base = QUERY_BASE_RESET;
  logic [EXT_W-1:0]   cfg_query_ext  = QUERY_EXT_RESET;
  logic [COUNT_W-1:0] cfg_limit      = LIST_LIMIT_RESET;
  bit                 scan_finished  = 1'b0;
  logic [COUNT_W-1:0] entries_listed = '0;

  scan_result_t pending_results[$];
  stim_row_t    dir_rows[$];
  scan_result_t oldest;
  int           mismatches = 0;
  int           burst_left = 0;
  int           accepted_entries = 0;
  int           reg_writes = 0;
  int           seen_by_status[8];
  logic [31:0]  ready_pattern = 32'hFFFF_FFFF;
  int           pattern_age = 0;

  // bytes at and after the first space become spaces
  function automatic logic [63:0] cut_word(logic [63:0] w, int nbytes);
    logic [63:0] r;
    bit          seen;
    r = w;
    seen = 1'b0;
    for (int i = 0; i < nbytes; i++) begin
      if (w[8*i +: 8] == BYTE_SPACE) seen = 1'b1;
      if (seen) r[8*i +: 8] = BYTE_SPACE;
    end
    return r;
  endfunction

  // keeps the first space, scrambles whatever follows it
  function automatic logic [63:0] scramble_tail(logic [63:0] w, int nbytes);
    logic [63:0] r;
    bit          seen;
    r = w;
    seen = 1'b0;
    for (int i = 0; i < nbytes; i++) begin
      if (seen) r[8*i +: 8] = 8'($urandom());
      if (w[8*i +: 8] == BYTE_SPACE) seen = 1'b1;
    end
    return r;
  endfunction

  function automatic logic [63:0] pack_name(string s);
    logic [63:0] w;
    w = {8{BYTE_SPACE}};
    for (int i = 0; i < s.len() && i < 8; i++) w[8*i +: 8] = s[i];
    return w;
  endfunction

  function automatic logic [EXT_W-1:0] pack_ext(string s);
    logic [63:0] w;
    w = pack_name(s);
    return w[EXT_W-1:0];
  endfunction

  function automatic logic [63:0] random_word(int len);
    logic [63:0] w;
    int          c;
    w = {8{BYTE_SPACE}};
    for (int i = 0; i < len && i < 8; i++) begin
      c = $urandom_range(0, 35);
      w[8*i +: 8] = (c < 26) ? 8'(8'h41 + c) : 8'(8'h30 + c - 26);
    end
    return w;
  endfunction

  function automatic scan_result_t classify_entry(dir_entry_t e);
    scan_result_t r;
    logic [7:0]   lead;
    r = '0;
    r.status = ST_SKIPPED;
    lead = e.name[7:0];
    if (e.first_entry) begin
      scan_finished = 1'b0;
      entries_listed = '0;
    end
    if (scan_finished) begin
      r.status = ST_IGNORED;
    end else if (cfg_mode == MODE_LIST && entries_listed >= cfg_limit) begin
      r.status = ST_FULL;
      scan_finished = 1'b1;
    end else if (lead == BYTE_END) begin
      r.status = ST_END;
      scan_finished = 1'b1;
    end else if (lead == BYTE_DELETED || e.attr == ATTR_LFN) begin
      r.status = ST_SKIPPED;
    end else if (cfg_mode == MODE_FIND) begin
      if (cut_word(e.name, 8) == cut_word(cfg_query_base, 8) &&
          cut_word({40'd0, e.ext}, 3) == cut_word({40'd0, cfg_query_ext}, 3)) begin
        r.status = ST_FOUND;
        r.cluster = {e.cluster_hi, e.cluster_lo};
        scan_finished = 1'b1;
      end
    end else if ((e.attr & ATTR_VOLUME) != 8'h00 || lead == BYTE_DOT) begin
      r.status = ST_SKIPPED;
    end else begin
      r.status = ST_LISTED;
      r.cluster = {e.cluster_hi, e.cluster_lo};
      r.is_dir = (e.attr & ATTR_DIR) != 8'h00;
      r.size = e.size;
      r.name = e.name;
      r.ext = e.ext;
      entries_listed = entries_listed + 16'd1;
      if (entries_listed >= cfg_limit) scan_finished = 1'b1;
    end
    r.listed = entries_listed;
    return r;
  endfunction

  function automatic dir_entry_t random_entry(bit first);
    dir_entry_t  e;
    logic [63:0] w;
    int          pick;
    e.first_entry = first;
    e.name = random_word($urandom_range(1, 8));
    w = random_word($urandom_range(0, 3));
    e.ext = w[EXT_W-1:0];
    e.attr = 8'($urandom()) & ~ATTR_VOLUME;
    e.cluster_hi = 16'($urandom());
    e.cluster_lo = 16'($urandom());
    e.size = $urandom();
    pick = $urandom_range(0, 99);
    if (pick < 6) begin
      e.name[7:0] = BYTE_END;
    end else if (pick < 12) begin
      e.name[7:0] = BYTE_DELETED;
    end else if (pick < 18) begin
      e.attr = ATTR_LFN;
    end else if (pick < 24) begin
      e.attr = e.attr | ATTR_VOLUME;
    end else if (pick < 30) begin
      e.name[7:0] = BYTE_DOT;
    end else if (pick < 40) begin
      e.name = {$urandom(), $urandom()};
      e.ext = 24'($urandom());
      e.attr = 8'($urandom());
    end else if (pick < 65) begin
      // query name with junk past the cut
      e.name = scramble_tail(cfg_query_base, 8);
      w = scramble_tail({40'd0, cfg_query_ext}, 3);
      e.ext = w[EXT_W-1:0];
    end
    return e;
  endfunction

  function automatic stim_row_t entry_row(bit first, logic [63:0] name,
                                          logic [EXT_W-1:0] ext, logic [7:0] attr,
                                          logic [31:0] cluster, logic [31:0] size);
    stim_row_t r;
    r.kind = ROW_ENTRY;
    r.reg_idx = CFG_SCAN_MODE;
    r.reg_value = '0;
    r.ent = {first, name, ext, attr, cluster, size};
    r.typed = 1'b0;
    r.st = ST_SKIPPED;
    r.cnt = '0;
    return r;
  endfunction

  function automatic stim_row_t with_result(stim_row_t r, status_t st,
                                            logic [COUNT_W-1:0] cnt);
    stim_row_t t;
    t = r;
    t.typed = 1'b1;
    t.st = st;
    t.cnt = cnt;
    return t;
  endfunction

  function automatic stim_row_t reg_row(cfg_idx_t idx, logic [63:0] value);
    stim_row_t r;
    r = entry_row(1'b0, '0, '0, '0, '0, '0);
    r.kind = ROW_REG;
    r.reg_idx = idx;
    r.reg_value = value;
    return r;
  endfunction

  task automatic set_register(cfg_idx_t idx, logic [63:0] value);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    case (idx)
      CFG_SCAN_MODE:  cfg_mode = mode_t'(value[0]);
      CFG_QUERY_BASE: cfg_query_base = value;
      CFG_QUERY_EXT:  cfg_query_ext = value[EXT_W-1:0];
      CFG_LIST_LIMIT: cfg_limit = value[COUNT_W-1:0];
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic wait_for_idle();
    @(negedge clk);
    entry_bus.valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    // extra margin after the last result word has been taken
    repeat (4) @(negedge clk);
  endtask

  task automatic send_entry(dir_entry_t e, bit typed, scan_result_t typed_res,
                            output status_t st);
    scan_result_t r;
    @(negedge clk);
    if (burst_left == 0) begin
      entry_bus.valid = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                : $urandom_range(1, 10);
    end
    entry_bus.valid = 1'b1;
    entry_bus.first_entry = e.first_entry;
    entry_bus.entry_name = e.name;
    entry_bus.entry_ext = e.ext;
    entry_bus.entry_attributes = e.attr;
    entry_bus.cluster_high_half = e.cluster_hi;
    entry_bus.cluster_low_half = e.cluster_lo;
    entry_bus.entry_file_size = e.size;
    @(posedge clk);
    while (!entry_bus.ready) @(posedge clk);
    r = classify_entry(e);
    pending_results.push_back(typed ? typed_res : r);
    st = r.status;
    accepted_entries++;
    burst_left--;
  endtask

  task automatic change_settings(bit every_reg);
    logic [63:0] v;
    if (every_reg || $urandom_range(0, 1) == 1)
      set_register(CFG_SCAN_MODE, 64'($urandom_range(0, 1)));
    if (every_reg || $urandom_range(0, 1) == 1) begin
      case ($urandom_range(0, 9))
        0: v = '1;
        1: v = '0;
        2: v = {$urandom(), $urandom()};
        default: v = random_word($urandom_range(1, 8));
      endcase
      set_register(CFG_QUERY_BASE, v);
    end
    if (every_reg || $urandom_range(0, 1) == 1) begin
      case ($urandom_range(0, 9))
        0: v = 64'hFF_FFFF;
        1: v = '0;
        2: v = 64'($urandom());
        3: v = random_word(0);
        default: v = random_word($urandom_range(1, 3));
      endcase
      set_register(CFG_QUERY_EXT, v);
    end
    if (every_reg || $urandom_range(0, 1) == 1) begin
      case ($urandom_range(0, 7))
        0: v = '0;
        1: v = 64'hFFFF;
        2: v = 64'($urandom_range(0, 65535));
        default: v = 64'($urandom_range(1, 12));
      endcase
      set_register(CFG_LIST_LIMIT, v);
    end
  endtask

  task automatic check_field(string field, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h got %h", $time, field, want, got);
      mismatches++;
    end
  endtask

  // receiver stalls: a rotating pattern, reloaded now and then
  always @(negedge clk) begin
    if (pattern_age == 0) begin
      case ($urandom_range(0, 3))
        0: ready_pattern = 32'hFFFF_FFFF;
        3: ready_pattern = 32'h1 | (32'h1 << $urandom_range(1, 31));
        default: ready_pattern = $urandom() | 32'h1;
      endcase
      pattern_age = 96;
    end else begin
      pattern_age--;
    end
    result_bus.ready = ready_pattern[0];
    ready_pattern = {ready_pattern[0], ready_pattern[31:1]};
  end

  always @(posedge clk) begin
    if (!rst && result_bus.valid && result_bus.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result word expected none got status %0d cluster %h", $time,
                 result_bus.status, result_bus.first_cluster);
        mismatches++;
      end else begin
        oldest = pending_results.pop_front();
        check_field("status", 64'(oldest.status), 64'(result_bus.status));
        check_field("first_cluster", 64'(oldest.cluster), 64'(result_bus.first_cluster));
        check_field("is_directory", 64'(oldest.is_dir), 64'(result_bus.is_directory));
        check_field("size_out", 64'(oldest.size), 64'(result_bus.size_out));
        check_field("name_out", oldest.name, result_bus.name_out);
        check_field("ext_out", 64'(oldest.ext), 64'(result_bus.ext_out));
        check_field("listed_so_far", 64'(oldest.listed), 64'(result_bus.listed_so_far));
      end
      seen_by_status[result_bus.status]++;
    end
  end

  initial begin
    #4_000_000;
    $display("%0t: timed out with %0d result words outstanding", $time,
             pending_results.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    scan_result_t typed_res;
    status_t      st;
    dir_entry_t   e;
    int           counted;
    int           dir_len;
    bit           first;
    logic [63:0]  deleted_name;

    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = CFG_SCAN_MODE;
    cfg_data = '0;
    entry_bus.valid = 1'b0;
    entry_bus.first_entry = 1'b0;
    entry_bus.entry_name = '0;
    entry_bus.entry_ext = '0;
    entry_bus.entry_attributes = '0;
    entry_bus.cluster_high_half = '0;
    entry_bus.cluster_low_half = '0;
    entry_bus.entry_file_size = '0;
    foreach (seen_by_status[i]) seen_by_status[i] = 0;
    counted = 0;
    deleted_name = 64'h2020_2020_204F_4FE5;

    // reset defaults: find mode, blank query, limit 16
    dir_rows.push_back(with_result(entry_row(1'b1, '0, pack_ext("TXT"), 8'h20, 32'h2,
                                             32'd10), ST_END, 16'd0));
    dir_rows.push_back(with_result(entry_row(1'b0, pack_name("JUNK"), pack_ext("DAT"),
                                             8'h20, 32'h3, 32'd20), ST_IGNORED, 16'd0));
    dir_rows.push_back(with_result(entry_row(1'b1, deleted_name, pack_ext("TXT"), 8'h20,
                                             32'h4, 32'd30), ST_SKIPPED, 16'd0));
    dir_rows.push_back(with_result(entry_row(1'b0, pack_name("FOO"), pack_ext("TXT"),
                                             ATTR_LFN, 32'h5, 32'd40), ST_SKIPPED, 16'd0));
    dir_rows.push_back(entry_row(1'b0, '1, '1, 8'hFF, '1, '1));
    // blank name against blank query
    dir_rows.push_back(entry_row(1'b0, pack_name(""), pack_ext(""), 8'h20,
                                 32'h1234_5678, 32'd50));
    dir_rows.push_back(with_result(entry_row(1'b0, pack_name("LATE"), pack_ext(""),
                                             8'h20, 32'h6, 32'd60), ST_IGNORED, 16'd0));
    dir_rows.push_back(reg_row(CFG_QUERY_BASE, pack_name("KERNEL")));
    dir_rows.push_back(reg_row(CFG_QUERY_EXT, 64'(pack_ext("BIN"))));
    // junk after the space is cut away
    dir_rows.push_back(entry_row(1'b1, pack_name("KERNEL X"), pack_ext("BIN"), 8'h01,
                                 32'hDEAD_0001, 32'd4096));
    // blank extension does not match a named one
    dir_rows.push_back(entry_row(1'b1, pack_name("KERNEL"), pack_ext(""), 8'h20,
                                 32'h7, 32'd70));
    dir_rows.push_back(reg_row(CFG_QUERY_EXT, 64'(pack_ext("B A"))));
    dir_rows.push_back(entry_row(1'b1, pack_name("KERNEL"), pack_ext("B"), 8'h20,
                                 32'h8, 32'd80));
    dir_rows.push_back(with_result(entry_row(1'b1, '0, '0, '0, '0, '0), ST_END, 16'd0));
    dir_rows.push_back(reg_row(CFG_SCAN_MODE, 64'(MODE_LIST)));
    dir_rows.push_back(reg_row(CFG_LIST_LIMIT, 64'd2));
    dir_rows.push_back(entry_row(1'b1, pack_name("."), pack_ext(""), ATTR_DIR,
                                 32'h9, 32'd0));
    dir_rows.push_back(entry_row(1'b0, pack_name("VOLUME"), pack_ext(""), ATTR_VOLUME,
                                 32'h0, 32'd0));
    dir_rows.push_back(entry_row(1'b0, pack_name("DOCS"), pack_ext(""), ATTR_DIR,
                                 32'h0000_0A00, 32'd0));
    dir_rows.push_back(entry_row(1'b0, '1, '1, 8'hF7, '1, '1));
    dir_rows.push_back(with_result(entry_row(1'b0, pack_name("MORE"), pack_ext("TXT"),
                                             8'h20, 32'hB, 32'd5), ST_IGNORED, 16'd2));
    dir_rows.push_back(reg_row(CFG_LIST_LIMIT, 64'd0));
    dir_rows.push_back(with_result(entry_row(1'b1, pack_name("ANY"), pack_ext("TXT"),
                                             8'h20, 32'hC, 32'd5), ST_FULL, 16'd0));
    dir_rows.push_back(reg_row(CFG_LIST_LIMIT, 64'hFFFF));
    dir_rows.push_back(entry_row(1'b1, pack_name("A"), pack_ext("C"), 8'h20,
                                 32'h0001_0000, 32'd1));
    dir_rows.push_back(entry_row(1'b0, pack_name("B"), pack_ext("H"), 8'h00,
                                 32'h0002_0000, 32'd2));
    // limit lowered under a running scan
    dir_rows.push_back(reg_row(CFG_LIST_LIMIT, 64'd1));
    dir_rows.push_back(with_result(entry_row(1'b0, pack_name("C"), pack_ext(""), 8'h20,
                                             32'hD, 32'd3), ST_FULL, 16'd2));
    // mode flipped mid scan
    dir_rows.push_back(reg_row(CFG_SCAN_MODE, 64'(MODE_FIND)));
    dir_rows.push_back(with_result(entry_row(1'b1, deleted_name, pack_ext(""), 8'h20,
                                             32'hE, 32'd4), ST_SKIPPED, 16'd0));
    dir_rows.push_back(reg_row(CFG_SCAN_MODE, 64'(MODE_LIST)));
    dir_rows.push_back(entry_row(1'b0, pack_name("D"), pack_ext("LOG"), 8'h20,
                                 32'hF, 32'd6));

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_REG) begin
        wait_for_idle();
        set_register(dir_rows[i].reg_idx, dir_rows[i].reg_value);
      end else begin
        typed_res = '0;
        typed_res.status = dir_rows[i].st;
        typed_res.listed = dir_rows[i].cnt;
        send_entry(dir_rows[i].ent, dir_rows[i].typed, typed_res, st);
      end
    end

    // random directories, each preceded by a random selection of register writes
    typed_res = '0;
    while (counted < RANDOM_ITEMS) begin
      wait_for_idle();
      change_settings(reg_writes < 16);
      dir_len = $urandom_range(8, 60);
      for (int k = 0; k < dir_len; k++) begin
        first = (k == 0) || (scan_finished && $urandom_range(0, 3) != 0) ||
                ($urandom_range(0, 39) == 0);
        e = random_entry(first);
        send_entry(e, 1'b0, typed_res, st);
        if (st != ST_IGNORED) counted++;
      end
    end

    wait_for_idle();
    repeat (6) @(posedge clk);
    $display("%0d entry words over %0d register writes", accepted_entries, reg_writes);
    $display("skipped %0d found %0d listed %0d end %0d full %0d ignored %0d",
             seen_by_status[ST_SKIPPED], seen_by_status[ST_FOUND],
             seen_by_status[ST_LISTED], seen_by_status[ST_END],
             seen_by_status[ST_FULL], seen_by_status[ST_IGNORED]);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/fdes_pkg.sv
rtl/fdes_if.sv
rtl/fdes_front.sv
rtl/fdes_queue.sv
rtl/fdes_back.sv
rtl/fat_directory_entry_scanner.sv
verif/fat_directory_entry_scanner_tb.sv
